// ===== src/sotq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sequential one-shot timer queue package
// Widths, reset values and the result word type shared by the timer queue.
// ----------------------------------------------------------------------------
package sotq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int OP_W        = 1;
	localparam int MS_W        = 16;
	localparam int ID_W        = 8;
	localparam int TPM_W       = 20;
	localparam int RL_W        = 16;
	localparam int PROD_W      = TPM_W + MS_W;
	localparam int PRESCALE_SH = 8;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(40000);

	localparam logic [OP_W-1:0] OP_TICK = 1'b0;
	localparam logic [OP_W-1:0] OP_PUSH = 1'b1;

	typedef struct packed {
		logic            fired;
		logic [ID_W-1:0] fired_id;
		logic            queue_drained;
		logic            push_dropped;
		logic            running;
	} result_t;

endpackage

// ===== src/sotq_intf.sv =====
// ----------------------------------------------------------------------------
// Sequential one-shot timer queue channels
// Valid/ready channels for the request word and the result word.
// ----------------------------------------------------------------------------
interface sotq_req_if;
	import sotq_pkg::*;

	logic            valid;
	logic            ready;
	logic [OP_W-1:0] op;
	logic [MS_W-1:0] delay_ms;
	logic [ID_W-1:0] callback_id;

	modport source(output valid, output op, output delay_ms, output callback_id, input ready);
	modport sink(input valid, input op, input delay_ms, input callback_id, output ready);
endinterface

interface sotq_rsp_if;
	import sotq_pkg::*;

	logic            valid;
	logic            ready;
	logic            fired;
	logic [ID_W-1:0] fired_id;
	logic            queue_drained;
	logic            push_dropped;
	logic            running;

	modport source(output valid, output fired, output fired_id, output queue_drained,
		output push_dropped, output running, input ready);
	modport sink(input valid, input fired, input fired_id, input queue_drained,
		input push_dropped, input running, output ready);
endinterface

// ===== src/sotq_mul.sv =====
// ----------------------------------------------------------------------------
// Timer queue shift-add multiplier
// Multiplies ticks per millisecond by a delay, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sotq_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sotq_pkg::TPM_W-1:0] mcand,
	input  logic [sotq_pkg::MS_W-1:0]  mplier,
	output logic                       done,
	output logic [sotq_pkg::PROD_W-1:0] product
);
	import sotq_pkg::*;

	localparam int CNT_W = $clog2(MS_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   bit_cnt_q;
	logic [MS_W-1:0]    mplier_q;
	logic [TPM_W-1:0]   mcand_q;
	logic [PROD_W-1:0]  acc_q;
	logic [PROD_W-1:0]  addend;

	assign addend = mplier_q[MS_W-1] ? PROD_W'(mcand_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q    <= 1'b1;
				bit_cnt_q <= '0;
			end else if (busy_q) begin
				bit_cnt_q <= bit_cnt_q + CNT_W'(1);
				if (bit_cnt_q == CNT_W'(MS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mplier_q <= mplier;
			mcand_q  <= mcand;
		end else if (busy_q) begin
			acc_q    <= {acc_q[PROD_W-2:0], 1'b0} + addend;
			mplier_q <= {mplier_q[MS_W-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== src/sequential_one_shot_timer_queue_core.sv =====
// Push: S_MUL runs the 16-step shift-add multiplier, then S_APPLY, then S_DONE.
// Tick: S_TICK, S_LOAD and S_SET if an expiry loads the next period, then S_DONE.
// One word is in work at a time: the next word is accepted only back in S_IDLE,
// and S_DONE stalls while the previous result still waits in the output register.
// Reset is asynchronous and clears all control state; the entry store is not initialised
// and needs no clearing pass, so the block is ready straight after reset.
// ----------------------------------------------------------------------------
// Sequential one-shot timer queue
// Runs queued one-shot delays on one timer and reports expiries per tick.
// ----------------------------------------------------------------------------
module sequential_one_shot_timer_queue_core #(
	parameter int QUEUE_DEPTH = sotq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sotq_req_if.sink                        req,
	sotq_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sotq_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sotq_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sotq_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import sotq_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_APPLY,
		S_TICK,
		S_LOAD,
		S_SET,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [TPM_W-1:0]  tpm_q;
	logic [ID_W-1:0]   id_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  cur_q;
	logic [RL_W-1:0]   counter_q;
	logic [RL_W-1:0]   period_q;
	logic              on_q;
	result_t           res_q;
	result_t           rsp_q;
	logic              rsp_valid_q;

	logic [ID_W-1:0]   id_mem [QUEUE_DEPTH];
	logic [RL_W-1:0]   rl_mem [QUEUE_DEPTH];
	logic [ID_W-1:0]   id_rd_q;
	logic [RL_W-1:0]   rl_rd_q;

	logic              accept;
	logic              mul_start;
	logic              mul_done;
	logic [PROD_W-1:0] mul_prod;
	logic [RL_W-1:0]   reload;
	logic              restart;
	logic              full;
	logic              append;
	logic [CNT_W-1:0]  cur_next;
	logic              cfg_write;

	sotq_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (tpm_q),
		.mplier  (req.delay_ms),
		.done    (mul_done),
		.product (mul_prod)
	);

	assign accept    = req.valid && req.ready;
	assign mul_start = accept && (req.op == OP_PUSH);
	assign reload    = mul_prod[PRESCALE_SH +: RL_W] - RL_W'(1);
	assign restart   = on_q && (id_rd_q == id_q);
	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign append    = !restart && !full;
	assign cur_next  = CNT_W'(cur_q) + CNT_W'(1);

	assign req.ready = (state_q == S_IDLE);

	assign cfg_write = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == 1'b0);
	assign pready    = 1'b1;
	assign prdata    = (paddr[APB_ADDR_W-1] == 1'b0) ? APB_DATA_W'(tpm_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q <= TPM_RESET;
		end else if (cfg_write) begin
			tpm_q <= pwdata[TPM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_APPLY && append) begin
			id_mem[cnt_q[IDX_W-1:0]] <= id_q;
			rl_mem[cnt_q[IDX_W-1:0]] <= reload;
		end
		id_rd_q <= id_mem[cur_q];
		rl_rd_q <= rl_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= req.callback_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cur_q       <= '0;
			counter_q   <= '0;
			period_q    <= '0;
			on_q        <= 1'b0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q   <= '0;
						state_q <= (req.op == OP_PUSH) ? S_MUL : S_TICK;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (restart) begin
						period_q  <= reload;
						counter_q <= '0;
					end else if (full) begin
						res_q.push_dropped <= 1'b1;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q == '0) begin
							cur_q     <= '0;
							period_q  <= reload;
							counter_q <= '0;
							on_q      <= 1'b1;
						end
					end
					res_q.running <= on_q || (append && !full);
					state_q       <= S_DONE;
				end
				S_TICK: begin
					if (on_q && (counter_q == period_q)) begin
						res_q.fired    <= 1'b1;
						res_q.fired_id <= id_rd_q;
						counter_q      <= '0;
						if (cur_next >= cnt_q) begin
							on_q                <= 1'b0;
							cur_q               <= '0;
							cnt_q               <= '0;
							res_q.queue_drained <= 1'b1;
							res_q.running       <= 1'b0;
							state_q             <= S_DONE;
						end else begin
							cur_q         <= cur_next[IDX_W-1:0];
							res_q.running <= 1'b1;
							state_q       <= S_LOAD;
						end
					end else begin
						if (on_q) begin
							counter_q <= counter_q + RL_W'(1);
						end
						res_q.running <= on_q;
						state_q       <= S_DONE;
					end
				end
				S_LOAD: begin
					state_q <= S_SET;
				end
				S_SET: begin
					period_q <= rl_rd_q;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.fired         = rsp_q.fired;
	assign rsp.fired_id      = rsp_q.fired_id;
	assign rsp.queue_drained = rsp_q.queue_drained;
	assign rsp.push_dropped  = rsp_q.push_dropped;
	assign rsp.running       = rsp_q.running;

`ifndef SYNTHESIS
	a_on_has_entries: assert property (@(posedge clk) disable iff (!arst_n)
		on_q == (cnt_q != '0))
		else $error("Timer state and entry count disagree.");

	a_cur_in_queue: assert property (@(posedge clk) disable iff (!arst_n)
		on_q |-> (CNT_W'(cur_q) < cnt_q))
		else $error("Current entry lies beyond the queue.");

	a_fire_not_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.fired && rsp_q.push_dropped))
		else $error("A result word both fires and drops.");

	a_drain_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.queue_drained) |-> (rsp_q.fired && !rsp_q.running))
		else $error("A drained result word is inconsistent.");

	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL))
		else $error("Multiplier finished outside the multiply state.");
`endif

endmodule
